// ----- src/cspd_pkg.sv -----
// Shared types and constants for the command-synced packet deframer.
// Depends on nothing; imported by the deframer top level and its checker.
package cspd_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] header_t;
    typedef logic [31:0] command_t;
    typedef logic [63:0] word_t;
    typedef logic [3:0]  nbytes_t;

    // Bytes packed into one result word.
    localparam int WORD_BYTES = 8;

    // Result budget of one input request, and the counter width it needs.
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = 7;

    // Command word after reset: 0x90, 0x34, 0x00, 0x00.
    localparam command_t CMD_RESET = 32'h9034_0000;

endpackage

// ----- src/cspd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the deframer byte store.
module cspd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/command_synced_packet_deframer_unit.sv -----
// Command-synced packet deframer: top level with the sequencer and the byte store.
// Depends on cspd_pkg and cspd_ram.
// Throughput: one byte request is taken per pass of the sequencer, which reads the store
// one byte a cycle through its single registered read port, pausing while it waits for a
// free output register. A byte that completes nothing costs a window scan of the buffer
// when unlocked. A complete packet adds a checking pass and the emission of its words.
// Reset is synchronous and active low; it clears all control state at once. The byte store
// has no clearing pass, since only bytes that were written are ever read.
module command_synced_packet_deframer_unit #(
    parameter int STORE_DEPTH = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration: command word, written at once when cfg_we is high.
    input  logic               cfg_we,
    input  cspd_pkg::command_t cfg_wdata,
    // Input byte stream.
    input  logic               s_valid,
    output logic               s_ready,
    input  cspd_pkg::byte_t    s_stream_byte,
    // Result words.
    output logic               m_valid,
    input  logic               m_ready,
    output cspd_pkg::header_t  m_packet_header,
    output cspd_pkg::byte_t    m_payload_length,
    output logic               m_first_since_lock,
    output cspd_pkg::word_t    m_payload_word,
    output cspd_pkg::nbytes_t  m_word_bytes,
    output logic               m_last_word
);

    import cspd_pkg::*;

    // The store is a ring; an index relative to the oldest byte needs one more bit than
    // a ring address so that it can hold the fill level itself.
    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE       = 3'd0; // waiting for a byte request
    localparam logic [2:0] ST_SCAN       = 3'd1; // unlocked: search for the command word
    localparam logic [2:0] ST_LEN        = 3'd2; // locked: fetch the length byte
    localparam logic [2:0] ST_LEN_WAIT   = 3'd3; // length byte arrives from the store
    localparam logic [2:0] ST_CHECK      = 3'd4; // checksum and command compare pass
    localparam logic [2:0] ST_EMIT_WAIT  = 3'd5; // wait for a free output register
    localparam logic [2:0] ST_EMIT_READ  = 3'd6; // gather the bytes of one result word
    localparam logic [2:0] ST_FINISH     = 3'd7; // remove the emitted packet

    // Ring address of base plus a relative index; the sum is always below twice the depth.
    function automatic logic [PTR_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= SUM_W'(STORE_DEPTH)) ? s - SUM_W'(STORE_DEPTH) : s;
        return t[PTR_W-1:0];
    endfunction

    logic [2:0]       state_reg, state_next;
    command_t         cmd_reg, cmd_next;
    logic [PTR_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             locked_reg, locked_next;
    logic             seen_reg, seen_next;
    logic [RES_W-1:0] cnt_reg, cnt_next;

    // Read pipeline: rd_k issues an index, dk/dv tag the data when it arrives in the next cycle.
    logic [CNT_W-1:0] rd_k_reg, rd_k_next;
    logic [CNT_W-1:0] dk_reg, dk_next;
    logic             dv_reg, dv_next;

    // Working registers of the passes.
    logic [23:0]      win_reg, win_next;
    byte_t            x_reg, x_next;
    logic             cmd_ok_reg, cmd_ok_next;
    logic             csum_ok_reg, csum_ok_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    byte_t            len_reg, len_next;
    header_t          hdr_reg, hdr_next;
    logic [CNT_W-1:0] wb_reg, wb_next;
    logic [CNT_W-1:0] wend_reg, wend_next;
    word_t            acc_reg, acc_next;
    logic [2:0]       bs_reg, bs_next;

    // Output register.
    logic             m_valid_reg, m_valid_next;
    header_t          m_header_reg, m_header_next;
    byte_t            m_len_reg, m_len_next;
    logic             m_first_reg, m_first_next;
    word_t            m_word_reg, m_word_next;
    nbytes_t          m_nb_reg, m_nb_next;
    logic             m_last_reg, m_last_next;

    // Store ports.
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [PTR_W-1:0] ram_raddr;
    byte_t            ram_rdata;
    logic [CNT_W-1:0] rd_idx;

    // Combinational helpers.
    logic             accept;
    logic             issue;
    logic             do_drop;
    logic [CNT_W-1:0] drop_n;
    logic             slot_free;
    logic             load;
    word_t            load_word;
    nbytes_t          load_nb;
    logic             load_last;
    logic [CNT_W-1:0] len_in_total;
    logic [CNT_W-1:0] len_p3;
    logic [CNT_W-1:0] wb_p8;
    logic [8:0]       words_sum;
    logic [5:0]       words;
    logic [RES_W:0]   budget_sum;
    command_t         cmd_shift;
    logic [1:0]       cmd_pos;
    logic             cmd_hit;
    logic             csum_now;
    logic             cmd_now;
    word_t            acc_ins;

    cspd_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(s_stream_byte),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // A request that finds the store full overwrites the oldest byte in place.
    assign ram_we    = accept;
    assign ram_waddr = (fill_reg == CNT_W'(STORE_DEPTH)) ? offset_reg
                     : wrap_idx(SUM_W'(offset_reg) + SUM_W'(fill_reg));

    // The length byte is always at relative index 2; every other pass uses rd_k.
    assign rd_idx    = (state_reg == ST_LEN) ? CNT_W'(2) : rd_k_reg;
    assign ram_raddr = wrap_idx(SUM_W'(offset_reg) + SUM_W'(rd_idx));

    assign slot_free = !m_valid_reg || m_ready;

    assign len_in_total = CNT_W'(ram_rdata) + CNT_W'(4);
    assign len_p3       = CNT_W'(len_reg) + CNT_W'(3);
    assign wb_p8        = wb_reg + CNT_W'(WORD_BYTES);
    assign words_sum    = {1'b0, len_reg} + 9'd7;
    assign words        = (len_reg == 8'd0) ? 6'd1 : words_sum[8:3];
    assign budget_sum   = (RES_W+1)'(cnt_reg) + (RES_W+1)'(words);

    // Command byte expected at relative index 3..6, most significant byte first.
    assign cmd_pos   = 2'(dk_reg - CNT_W'(3));
    assign cmd_shift = cmd_reg << {cmd_pos, 3'b000};
    assign cmd_hit   = (dk_reg >= CNT_W'(3) && dk_reg <= CNT_W'(6))
                     ? (ram_rdata == cmd_shift[31:24]) : 1'b1;
    assign csum_now  = (dk_reg == len_p3) ? (x_reg == ram_rdata) : csum_ok_reg;
    assign cmd_now   = cmd_ok_reg && cmd_hit;

    // Place the arriving payload byte in its slot of the word, earliest byte on top.
    assign acc_ins = acc_reg | ({ram_rdata, 56'd0} >> {bs_reg, 3'b000});

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cfg_we ? cfg_wdata : cmd_reg;
        offset_next  = offset_reg;
        fill_next    = fill_reg;
        locked_next  = locked_reg;
        seen_next    = seen_reg;
        cnt_next     = cnt_reg;
        rd_k_next    = rd_k_reg;
        win_next     = win_reg;
        x_next       = x_reg;
        cmd_ok_next  = cmd_ok_reg;
        csum_ok_next = csum_ok_reg;
        hi_next      = hi_reg;
        len_next     = len_reg;
        hdr_next     = hdr_reg;
        wb_next      = wb_reg;
        wend_next    = wend_reg;
        acc_next     = acc_reg;
        bs_next      = bs_reg;
        issue        = 1'b0;
        do_drop      = 1'b0;
        drop_n       = '0;
        load         = 1'b0;
        load_word    = '0;
        load_nb      = '0;
        load_last    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (fill_reg == CNT_W'(STORE_DEPTH)) begin
                        offset_next = wrap_idx(SUM_W'(offset_reg) + SUM_W'(1));
                    end else begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    cnt_next  = '0;
                    rd_k_next = CNT_W'(3);
                    state_next = locked_reg ? ST_LEN : ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Slide a 4-byte window from index 3; a hit at index k locks at k-6.
                if (fill_reg < CNT_W'(7)) begin
                    state_next = ST_IDLE;
                end else begin
                    issue = (rd_k_reg < fill_reg);
                    if (issue) begin
                        rd_k_next = rd_k_reg + CNT_W'(1);
                    end
                    if (dv_reg) begin
                        win_next = {win_reg[15:0], ram_rdata};
                        if (dk_reg >= CNT_W'(6) && {win_reg, ram_rdata} == cmd_reg) begin
                            do_drop     = 1'b1;
                            drop_n      = dk_reg - CNT_W'(6);
                            locked_next = 1'b1;
                            seen_next   = 1'b0;
                            state_next  = ST_LEN;
                        end else if (dk_reg == fill_reg - CNT_W'(1)) begin
                            // Every earlier start has failed: keep only the last six bytes.
                            do_drop    = 1'b1;
                            drop_n     = fill_reg - CNT_W'(6);
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_LEN: begin
                state_next = (fill_reg < CNT_W'(3)) ? ST_IDLE : ST_LEN_WAIT;
            end

            ST_LEN_WAIT: begin
                if (fill_reg < len_in_total) begin
                    state_next = ST_IDLE;
                end else begin
                    len_next     = ram_rdata;
                    rd_k_next    = '0;
                    x_next       = '0;
                    cmd_ok_next  = (fill_reg >= CNT_W'(7));
                    csum_ok_next = 1'b0;
                    // A short packet still needs bytes 3..6 for the command test on failure.
                    if (ram_rdata >= 8'd3 || fill_reg < CNT_W'(7)) begin
                        hi_next = CNT_W'(ram_rdata) + CNT_W'(3);
                    end else begin
                        hi_next = CNT_W'(6);
                    end
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK: begin
                issue = (rd_k_reg <= hi_reg);
                if (issue) begin
                    rd_k_next = rd_k_reg + CNT_W'(1);
                end
                if (dv_reg) begin
                    if (dk_reg == CNT_W'(0)) begin
                        hdr_next[15:8] = ram_rdata;
                    end
                    if (dk_reg == CNT_W'(1)) begin
                        hdr_next[7:0] = ram_rdata;
                    end
                    if (dk_reg < len_p3) begin
                        x_next = x_reg ^ ram_rdata;
                    end
                    csum_ok_next = csum_now;
                    cmd_ok_next  = cmd_now;
                    if (dk_reg == hi_reg) begin
                        if (!csum_now) begin
                            // A failing command packet loses its first seven bytes,
                            // any other failing packet only its first byte.
                            do_drop     = 1'b1;
                            drop_n      = cmd_now ? CNT_W'(7) : CNT_W'(1);
                            locked_next = 1'b0;
                            rd_k_next   = CNT_W'(3);
                            state_next  = ST_SCAN;
                        end else if (budget_sum > (RES_W+1)'(MAX_RESULTS)) begin
                            state_next = ST_IDLE;
                        end else begin
                            wb_next    = CNT_W'(3);
                            state_next = ST_EMIT_WAIT;
                        end
                    end
                end
            end

            ST_EMIT_WAIT: begin
                if (slot_free) begin
                    if (len_reg == 8'd0) begin
                        load       = 1'b1;
                        load_last  = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        wend_next  = (wb_p8 < len_p3) ? wb_p8 : len_p3;
                        rd_k_next  = wb_reg;
                        bs_next    = '0;
                        acc_next   = '0;
                        state_next = ST_EMIT_READ;
                    end
                end
            end

            ST_EMIT_READ: begin
                issue = (rd_k_reg < wend_reg);
                if (issue) begin
                    rd_k_next = rd_k_reg + CNT_W'(1);
                end
                if (dv_reg) begin
                    acc_next = acc_ins;
                    bs_next  = bs_reg + 3'd1;
                    if (dk_reg == wend_reg - CNT_W'(1)) begin
                        // The output register was free when this word started.
                        load      = 1'b1;
                        load_word = acc_ins;
                        load_nb   = 4'(wend_reg - wb_reg);
                        load_last = (wend_reg == len_p3);
                        wb_next   = wend_reg;
                        state_next = (wend_reg == len_p3) ? ST_FINISH : ST_EMIT_WAIT;
                    end
                end
            end

            ST_FINISH: begin
                do_drop    = 1'b1;
                drop_n     = CNT_W'(len_reg) + CNT_W'(4);
                seen_next  = 1'b1;
                state_next = ST_LEN;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_drop) begin
            offset_next = wrap_idx(SUM_W'(offset_reg) + SUM_W'(drop_n));
            fill_next   = fill_reg - drop_n;
        end
        if (load) begin
            cnt_next = cnt_reg + RES_W'(1);
        end
    end

    // A read in flight is dropped whenever the sequencer leaves the state that issued it.
    assign dv_next = issue && (state_next == state_reg);
    assign dk_next = rd_k_reg;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_header_next = m_header_reg;
        m_len_next    = m_len_reg;
        m_first_next  = m_first_reg;
        m_word_next   = m_word_reg;
        m_nb_next     = m_nb_reg;
        m_last_next   = m_last_reg;
        if (load) begin
            m_valid_next  = 1'b1;
            m_header_next = hdr_reg;
            m_len_next    = len_reg;
            m_first_next  = !seen_reg;
            m_word_next   = load_word;
            m_nb_next     = load_nb;
            m_last_next   = load_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmd_reg     <= CMD_RESET;
            offset_reg  <= '0;
            fill_reg    <= '0;
            locked_reg  <= 1'b0;
            seen_reg    <= 1'b0;
            cnt_reg     <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            offset_reg  <= offset_next;
            fill_reg    <= fill_next;
            locked_reg  <= locked_next;
            seen_reg    <= seen_next;
            cnt_reg     <= cnt_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_k_reg     <= rd_k_next;
        dk_reg       <= dk_next;
        win_reg      <= win_next;
        x_reg        <= x_next;
        cmd_ok_reg   <= cmd_ok_next;
        csum_ok_reg  <= csum_ok_next;
        hi_reg       <= hi_next;
        len_reg      <= len_next;
        hdr_reg      <= hdr_next;
        wb_reg       <= wb_next;
        wend_reg     <= wend_next;
        acc_reg      <= acc_next;
        bs_reg       <= bs_next;
        m_header_reg <= m_header_next;
        m_len_reg    <= m_len_next;
        m_first_reg  <= m_first_next;
        m_word_reg   <= m_word_next;
        m_nb_reg     <= m_nb_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_packet_header    = m_header_reg;
    assign m_payload_length   = m_len_reg;
    assign m_first_since_lock = m_first_reg;
    assign m_payload_word     = m_word_reg;
    assign m_word_bytes       = m_nb_reg;
    assign m_last_word        = m_last_reg;

endmodule

// ----- src/cspd_checker.sv -----
// Port-level checker for the command-synced packet deframer, bound to its top level.
// Depends on cspd_pkg.
module cspd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_we,
    input cspd_pkg::command_t cfg_wdata,
    input logic               s_valid,
    input logic               s_ready,
    input cspd_pkg::byte_t    s_stream_byte,
    input logic               m_valid,
    input logic               m_ready,
    input cspd_pkg::header_t  m_packet_header,
    input cspd_pkg::byte_t    m_payload_length,
    input logic               m_first_since_lock,
    input cspd_pkg::word_t    m_payload_word,
    input cspd_pkg::nbytes_t  m_word_bytes,
    input logic               m_last_word
);

    import cspd_pkg::*;

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_word)
            && $stable(m_word_bytes) && $stable(m_last_word))
        else $error("stalled result changed");

    // Each accepted byte starts a processing pass, during which ready is low.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after a byte request");

    // Only the last word of a packet may be partly filled.
    a_full_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_word |-> m_word_bytes == nbytes_t'(WORD_BYTES))
        else $error("partial word before the end of a packet");

    // A word never holds more bytes than fit.
    a_nb_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word_bytes <= nbytes_t'(WORD_BYTES))
        else $error("word byte count out of range");

    // An empty word only stands for an empty payload.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word_bytes == '0 |-> m_last_word && m_payload_length == '0
            && m_payload_word == '0)
        else $error("empty word outside an empty packet");

endmodule

bind command_synced_packet_deframer_unit cspd_checker u_cspd_checker (.*);

// ----- sim/command_synced_packet_deframer_unit_test.sv -----
// Self-checking testbench for the command-synced packet deframer: directed frames, then
// random framed traffic under several idle, stall and back-pressure patterns.
// Depends on cspd_pkg and command_synced_packet_deframer_unit; needs nothing else.
module command_synced_packet_deframer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cspd_pkg::*;

    localparam int STORE_DEPTH = 512;
    // The random part sends at least this many bytes per phase, over five phases.
    localparam int unsigned PHASE_BYTES = 54;
    // Quiet time after the last expected word. A failed long frame can leave a few
    // hundred bytes to rescan, each scan running over the buffered bytes.
    localparam int unsigned SETTLE_CYCLES = 5000;
    // Long receiver hold-off in the back-pressure phase.
    localparam int unsigned HOLD_CYCLES = 1500;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;

    // One result word as the block presents it.
    typedef struct packed {
        header_t hdr;
        byte_t   len;
        logic    first;
        word_t   word;
        nbytes_t nb;
        logic    last;
    } frame_word_t;

    // One directed frame. The first payload bytes come from lead (or from the sync
    // command when lead_cmd is set), any bytes past the eighth are 0xFF.
    typedef struct {
        header_t     hdr;
        int unsigned plen;
        word_t       lead;
        bit          lead_cmd;
        bit          corrupt;
        bit          typed;
        frame_word_t want;
    } frame_row_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     cfg_we = 1'b0;
    command_t cfg_wdata = CMD_RESET;
    logic     s_valid = 1'b0;
    logic     s_ready;
    byte_t    s_stream_byte = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    header_t  m_packet_header;
    byte_t    m_payload_length;
    logic     m_first_since_lock;
    word_t    m_payload_word;
    nbytes_t  m_word_bytes;
    logic     m_last_word;

    // Predictor state: the buffered link bytes, oldest first, and the lock flags.
    byte_t    link_bytes[$];
    command_t sync_cmd = CMD_RESET;
    bit       is_locked = 1'b0;
    bit       had_good_frame = 1'b0;

    // Words still owed by the block, oldest first.
    frame_word_t pending_words[$];
    int unsigned words_predicted = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Idle and stall rates in percent, and the back-pressure hold-off controls.
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_go = 1'b0;
    logic hold_active = 1'b0;

    // The directed frames, all under the reset command 0x90340000. The first locks
    // straight after reset, so its word is flagged as the first since lock. The empty
    // payload gives a single word with no valid bytes. The nine-byte frame splits over
    // two words and carries the byte extremes. A bad non-command frame then unlocks
    // the block, a bad command frame locks and unlocks it again, and the last frame
    // relocks one byte into the buffer, so its word is once more the first since lock.
    frame_row_t dir_rows [6] = '{
        '{hdr: 16'h0000, plen: 4, lead: '0, lead_cmd: 1'b1, corrupt: 1'b0, typed: 1'b1,
          want: '{hdr: 16'h0000, len: 8'd4, first: 1'b1, word: 64'h9034_0000_0000_0000,
                  nb: 4'd4, last: 1'b1}},
        '{hdr: 16'hFFFF, plen: 0, lead: '0, lead_cmd: 1'b0, corrupt: 1'b0, typed: 1'b1,
          want: '{hdr: 16'hFFFF, len: 8'd0, first: 1'b0, word: '0, nb: 4'd0,
                  last: 1'b1}},
        '{hdr: 16'h7E81, plen: 9, lead: 64'h00FF_0102_8040_AA55, lead_cmd: 1'b0,
          corrupt: 1'b0, typed: 1'b0, want: '0},
        '{hdr: 16'h1234, plen: 0, lead: '0, lead_cmd: 1'b0, corrupt: 1'b1, typed: 1'b0,
          want: '0},
        '{hdr: 16'hC3C3, plen: 4, lead: '0, lead_cmd: 1'b1, corrupt: 1'b1, typed: 1'b0,
          want: '0},
        '{hdr: 16'hA5A5, plen: 5, lead: 64'h0000_0000_5A00_0000, lead_cmd: 1'b1,
          corrupt: 1'b0, typed: 1'b1,
          want: '{hdr: 16'hA5A5, len: 8'd5, first: 1'b1, word: 64'h9034_0000_5A00_0000,
                  nb: 4'd5, last: 1'b1}}
    };

    command_synced_packet_deframer_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_stream_byte      (s_stream_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_packet_header    (m_packet_header),
        .m_payload_length   (m_payload_length),
        .m_first_since_lock (m_first_since_lock),
        .m_payload_word     (m_payload_word),
        .m_word_bytes       (m_word_bytes),
        .m_last_word        (m_last_word)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void drop_oldest(int unsigned n);
        repeat (n) begin
            if (link_bytes.size() != 0) void'(link_bytes.pop_front());
        end
    endfunction

    // True when the four bytes at offsets 3..6 from position k hold the sync
    // command. Bytes not yet buffered never match.
    function automatic bit command_at(int unsigned k);
        if (link_bytes.size() < k + 7) return 1'b0;
        for (int unsigned i = 0; i < 4; i++) begin
            if (link_bytes[k + 3 + i] != sync_cmd[31 - 8 * i -: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Takes one link byte and appends every word it releases to words_out. The loop
    // runs until nothing more can be done with the buffered bytes: search for the
    // command while unlocked, then check and emit whole frames while locked.
    function automatic void deframe_byte(input byte_t b, ref frame_word_t words_out[$]);
        int unsigned plen, total, nwords, nb, emitted, j;
        byte_t       sum;
        bit          found;
        frame_word_t fw;
        emitted = 0;
        if (link_bytes.size() >= STORE_DEPTH) void'(link_bytes.pop_front());
        link_bytes.push_back(b);
        while (1) begin
            if (!is_locked) begin
                found = 1'b0;
                j = 0;
                while (j + 7 <= link_bytes.size()) begin
                    if (command_at(j)) begin
                        found = 1'b1;
                        break;
                    end
                    j++;
                end
                // Without a match every earlier position is dead; keep only the tail
                // that could still grow into a command window.
                if (!found) begin
                    if (link_bytes.size() > 6) drop_oldest(link_bytes.size() - 6);
                    break;
                end
                drop_oldest(j);
                is_locked = 1'b1;
                had_good_frame = 1'b0;
            end
            if (link_bytes.size() < 3) break;
            plen = link_bytes[2];
            total = plen + 4;
            if (link_bytes.size() < total) break;
            sum = '0;
            for (int unsigned i = 0; i < plen + 3; i++) sum ^= link_bytes[i];
            if (sum != link_bytes[plen + 3]) begin
                // A failing command frame restarts the search after its command,
                // any other failing frame at its second byte.
                drop_oldest(command_at(0) ? 7 : 1);
                is_locked = 1'b0;
                continue;
            end
            // A good frame that would overrun the per-byte word budget waits for a
            // later byte.
            nwords = (plen == 0) ? 1 : (plen + 7) / 8;
            if (emitted + nwords > MAX_RESULTS) break;
            for (int unsigned w = 0; w < nwords; w++) begin
                fw = '0;
                fw.hdr = {link_bytes[0], link_bytes[1]};
                fw.len = plen[7:0];
                fw.first = !had_good_frame;
                nb = 0;
                if (plen > 8 * w) nb = (plen - 8 * w > 8) ? 8 : plen - 8 * w;
                for (int unsigned k = 0; k < nb; k++)
                    fw.word[63 - 8 * k -: 8] = link_bytes[3 + 8 * w + k];
                fw.nb = nb[3:0];
                fw.last = (w + 1 == nwords);
                words_out.push_back(fw);
                emitted++;
                words_predicted++;
            end
            drop_oldest(total);
            had_good_frame = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- frame building

    // Appends one frame with random payload. With lead_cmd the payload opens with the
    // current sync command; a corrupt frame gets a checksum that is always wrong.
    function automatic void build_frame(ref byte_t fr[$], input header_t hdr,
                                        input int unsigned plen, input bit lead_cmd,
                                        input bit corrupt);
        byte_t b, sum;
        fr.push_back(hdr[15:8]);
        fr.push_back(hdr[7:0]);
        fr.push_back(byte_t'(plen));
        sum = hdr[15:8] ^ hdr[7:0] ^ byte_t'(plen);
        for (int unsigned i = 0; i < plen; i++) begin
            if (lead_cmd && i < 4) b = sync_cmd[31 - 8 * i -: 8];
            else b = byte_t'($urandom_range(0, 255));
            fr.push_back(b);
            sum ^= b;
        end
        if (corrupt) sum ^= byte_t'($urandom_range(1, 255));
        fr.push_back(sum);
    endfunction

    // Appends a bad frame whose payload is a command frame followed by n_empty empty
    // frames. When the outer frame fails, the rescan finds them all in one go.
    function automatic void build_burst(ref byte_t fr[$], input int unsigned n_empty);
        byte_t inner[$];
        build_frame(inner, header_t'($urandom_range(0, 65535)), 4, 1'b1, 1'b0);
        repeat (n_empty) build_frame(inner, header_t'($urandom_range(0, 65535)), 0, 1'b0,
                                     1'b0);
        build_frame(fr, header_t'($urandom_range(0, 65535)), 0, 1'b0, 1'b0);
        // Turn the empty outer frame into one that wraps the inner bytes.
        void'(fr.pop_back());
        void'(fr.pop_back());
        fr.push_back(byte_t'(inner.size()));
        foreach (inner[i]) fr.push_back(inner[i]);
        // Random checksum byte: almost always wrong, and fine either way.
        fr.push_back(byte_t'($urandom_range(0, 255)));
    endfunction

    // Payload lengths: mostly short, some medium, a few up to the maximum.
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 90) return $urandom_range(0, 24);
        if (r < 97) return $urandom_range(25, 80);
        return $urandom_range(81, 255);
    endfunction

    // ---------------------------------------------------------------- driving

    // Offers one byte request and returns at the edge where it is taken. Valid stays
    // high across back-to-back requests, so it is only lowered for a real gap.
    task automatic offer_byte(input byte_t b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_stream_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_frame(input byte_t fr[$]);
        foreach (fr[i]) begin
            offer_byte(fr[i]);
            deframe_byte(fr[i], pending_words);
        end
    endtask

    // Waits for every owed word, then lets the block finish any silent rescans.
    task automatic wait_quiet();
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_command(input command_t c);
        cfg_we <= 1'b1;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sync_cmd = c;
    endtask

    // One random phase under a fresh command. While the predictor says the block is
    // unlocked, most picks are command frames, so that traffic keeps getting past the
    // search; the rest is good, bad, cut-short and noise traffic.
    task automatic run_phase(input command_t cmd, input int idle_pct, input int stall,
                             input bit squeeze, input bit lead_long);
        byte_t       fr[$];
        int unsigned sent, words_base, r, keep;
        wait_quiet();
        load_command(cmd);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        sent = 0;
        words_base = words_predicted;
        if (squeeze) hold_go = 1'b1;
        if (lead_long) begin
            // Lock, a maximum-length frame, then a failing frame that hides a run of
            // sixty-two good frames for the rescan.
            build_frame(fr, header_t'($urandom_range(0, 65535)), 4, 1'b1, 1'b0);
            build_frame(fr, header_t'($urandom_range(0, 65535)), 255, 1'b0, 1'b0);
            build_burst(fr, 61);
            send_frame(fr);
        end
        while (sent < PHASE_BYTES || words_predicted - words_base < 12) begin
            fr.delete();
            r = $urandom_range(0, 99);
            if (!is_locked && r < 85) begin
                build_frame(fr, header_t'($urandom_range(0, 65535)), $urandom_range(4, 20),
                            1'b1, 1'b0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    build_frame(fr, header_t'($urandom_range(0, 65535)), pick_len(), 1'b0,
                                1'b0);
                end else if (r < 63) begin
                    build_frame(fr, header_t'($urandom_range(0, 65535)),
                                $urandom_range(4, 24), 1'b1, 1'b0);
                end else if (r < 75) begin
                    if ($urandom_range(0, 1) == 1)
                        build_frame(fr, header_t'($urandom_range(0, 65535)),
                                    $urandom_range(4, 16), 1'b1, 1'b1);
                    else
                        build_frame(fr, header_t'($urandom_range(0, 65535)), pick_len(),
                                    1'b0, 1'b1);
                end else if (r < 85) begin
                    repeat ($urandom_range(1, 6)) fr.push_back(byte_t'($urandom_range(0, 255)));
                end else if (r < 95) begin
                    // A frame cut short: the next bytes get swallowed into it.
                    build_frame(fr, header_t'($urandom_range(0, 65535)), pick_len(), 1'b0,
                                1'b0);
                    keep = $urandom_range(1, fr.size() - 1);
                    while (fr.size() > keep) void'(fr.pop_back());
                end else begin
                    build_burst(fr, $urandom_range(1, 20));
                end
            end
            sent += fr.size();
            send_frame(fr);
        end
        s_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void compare_word(input frame_word_t got);
        frame_word_t exp;
        if (pending_words.size() == 0) begin
            $error("result word with nothing expected: header %h", got.hdr);
            mismatches++;
            return;
        end
        exp = pending_words.pop_front();
        if (got.hdr !== exp.hdr) begin
            $error("packet_header: expected %h, got %h", exp.hdr, got.hdr);
            mismatches++;
        end
        if (got.len !== exp.len) begin
            $error("payload_length: expected %0d, got %0d", exp.len, got.len);
            mismatches++;
        end
        if (got.first !== exp.first) begin
            $error("first_since_lock: expected %b, got %b", exp.first, got.first);
            mismatches++;
        end
        if (got.word !== exp.word) begin
            $error("payload_word: expected %h, got %h", exp.word, got.word);
            mismatches++;
        end
        if (got.nb !== exp.nb) begin
            $error("word_bytes: expected %0d, got %0d", exp.nb, got.nb);
            mismatches++;
        end
        if (got.last !== exp.last) begin
            $error("last_word: expected %b, got %b", exp.last, got.last);
            mismatches++;
        end
    endfunction

    // Receiver: takes a word at each edge where valid and ready were both high, then
    // picks ready for the next cycle. The hold-off overrides the random stalls.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                compare_word('{hdr: m_packet_header, len: m_payload_length,
                               first: m_first_since_lock, word: m_payload_word,
                               nb: m_word_bytes, last: m_last_word});
            end
            m_ready <= !hold_active && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Back-pressure: once asked, the receiver refuses words for a long stretch while
    // the sender keeps offering, so the block backs up and stops taking requests.
    initial begin
        wait (hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        byte_t       fr[$];
        frame_word_t got_words[$];
        byte_t       b, sum;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames. Typed rows are checked against the word written in the
        // table; the predictor still sees every byte to keep its state in step.
        foreach (dir_rows[r]) begin
            fr.delete();
            fr.push_back(dir_rows[r].hdr[15:8]);
            fr.push_back(dir_rows[r].hdr[7:0]);
            fr.push_back(byte_t'(dir_rows[r].plen));
            for (int unsigned i = 0; i < dir_rows[r].plen; i++) begin
                if (dir_rows[r].lead_cmd && i < 4) b = sync_cmd[31 - 8 * i -: 8];
                else if (i < 8) b = dir_rows[r].lead[63 - 8 * i -: 8];
                else b = 8'hFF;
                fr.push_back(b);
            end
            sum = '0;
            foreach (fr[i]) sum ^= fr[i];
            if (dir_rows[r].corrupt) sum ^= 8'h5A;
            fr.push_back(sum);
            foreach (fr[i]) begin
                offer_byte(fr[i]);
                got_words.delete();
                deframe_byte(fr[i], got_words);
                if (dir_rows[r].typed && i == fr.size() - 1)
                    pending_words.push_back(dir_rows[r].want);
                else
                    foreach (got_words[k]) pending_words.push_back(got_words[k]);
            end
        end
        s_valid <= 1'b0;

        // Random phases, each under its own command word: the all-ones and all-zero
        // extremes, a random word, the reset word, and a random word for the
        // back-pressure phase.
        run_phase(32'hFFFF_FFFF, 0, 0, 1'b0, 1'b1);
        run_phase(32'h0000_0000, 65, 0, 1'b0, 1'b0);
        run_phase(command_t'($urandom), 0, 65, 1'b0, 1'b0);
        run_phase(CMD_RESET, 19, 19, 1'b0, 1'b0);
        run_phase(command_t'($urandom), 0, 0, 1'b1, 1'b0);
        wait_quiet();

        if (mismatches == 0 && pending_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/cspd_pkg.sv
src/cspd_ram.sv
src/command_synced_packet_deframer_unit.sv
src/cspd_checker.sv
sim/command_synced_packet_deframer_unit_test.sv
